/* design/clrc_pkg.sv */
// Shared types and constants for the character LCD refresh controller.
// No dependencies; imported by the top level and the testbench.
package clrc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ROW_COUNT   = 3'd0;
    localparam logic [2:0] CFG_COL_COUNT   = 3'd1;
    localparam logic [2:0] CFG_NIBBLE_MODE = 3'd2;
    localparam logic [2:0] CFG_ROW3_ADDR   = 3'd3;
    localparam logic [2:0] CFG_ROW4_ADDR   = 3'd4;

    localparam logic [7:0] CMD_WAKE       = 8'h30;
    localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
    localparam logic [7:0] ROW2_ADDR      = 8'h40;
    localparam logic [6:0] WAIT_LONG      = 7'd80;
    localparam logic [6:0] WAIT_SHORT     = 7'd10;
    localparam logic [3:0] LAST_STEP_NIB  = 4'd7;
    localparam logic [3:0] LAST_STEP_BYTE = 4'd6;
    localparam logic [3:0] FIRST_FULL_NIB = 4'd5;

    // where the output stage takes the bus byte from
    typedef enum logic [1:0] {
        SRC_KEEP,
        SRC_CONST,
        SRC_MEM
    } t_src;

    // control carried from the read stage to the output stage
    typedef struct packed {
        t_src       src;
        logic [7:0] const_byte;
        logic       sel;
        logic       nib;
        logic       shift;
        logic       enable;
    } t_step;

    function automatic logic [7:0] power_up_byte(input logic [3:0] step,
                                                 input logic nib,
                                                 input logic multi);
        logic [7:0] b;
        b = 8'h0C;
        if (nib) begin
            unique case (step)
                4'd2, 4'd3: b = 8'h30;
                4'd4:       b = 8'h20;
                4'd5:       b = multi ? 8'h28 : 8'h20;
                4'd6:       b = 8'h08;
                4'd7:       b = 8'h06;
                default:    b = 8'h0C;
            endcase
        end else begin
            unique case (step)
                4'd2, 4'd3: b = 8'h30;
                4'd4:       b = multi ? 8'h38 : 8'h30;
                4'd5:       b = 8'h08;
                4'd6:       b = 8'h06;
                default:    b = 8'h0C;
            endcase
        end
        return b;
    endfunction

endpackage

/* design/character_lcd_refresh_controller.sv */
// Character LCD refresh controller: power-up sequencer, refresh walk and text buffer.
// Depends on clrc_pkg.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_op, i_write_position, i_write_char
//  result    out        o_valid / i_stall    o_bus_data, o_register_select, o_enable_strobe
//  config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One item per cycle unless the input stalls. A tick updates the sequencer state and reads
// the text buffer at its accept edge; the result, formed from the buffer read data, lands in
// the output register as the middle stage advances. A write item stores into the buffer only.
// Synchronous active-low reset; buffer entries read as zero until written (valid bits).
// The input stalls only while the middle stage holds an item behind a stalled output.
module character_lcd_refresh_controller
    import clrc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [6:0] i_write_position,
    input  logic [7:0] i_write_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_bus_data,
    output logic       o_register_select,
    output logic       o_enable_strobe
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [6:0] DEPTH_LIM = 7'(BUFFER_DEPTH);

    // configuration
    logic [2:0] r_row_count;
    logic [4:0] r_col_count;
    logic       r_nibble_mode;
    logic [6:0] r_row3_addr;
    logic [6:0] r_row4_addr;

    // sequencer state
    logic       r_init_done, n_init_done;
    logic       r_data_phase, n_data_phase;
    logic       r_low_pend, n_low_pend;
    logic       r_strobe_all, n_strobe_all;
    logic       r_sel, n_sel;
    logic [3:0] r_init_step, n_init_step;
    logic [6:0] r_wait, n_wait;
    logic [6:0] r_char_idx, n_char_idx;
    logic [4:0] r_col_idx, n_col_idx;
    logic [1:0] r_row_idx, n_row_idx;
    logic [7:0] r_cur_byte;

    // text buffer
    logic [7:0]              mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_mem_valid;
    logic [7:0]              r_rd_data;
    logic                    r_rd_ok;

    // pipeline
    logic  r_s1_valid;
    t_step r_s1;
    t_step s0;
    logic  r_o_valid;

    logic       accept, tick_acc, wr_acc, s1_adv;
    logic [2:0] rows;
    logic [4:0] cols;
    logic [6:0] span;
    logic [4:0] col_inc;
    logic [6:0] row_addr;
    logic       pend;
    logic       rd_in_range;
    logic       wr_in_range;
    logic [7:0] cb;

    assign s1_adv   = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign accept   = i_valid && !o_stall;
    assign tick_acc = accept && !i_op;
    assign wr_acc   = accept && i_op;
    assign o_valid  = r_o_valid;

    assign rows = (r_row_count == 3'd0) ? 3'd1 : (r_row_count > 3'd4) ? 3'd4 : r_row_count;
    assign cols = (r_col_count == 5'd0) ? 5'd1 : r_col_count;
    assign span = {4'b0, rows} * {2'b0, cols};
    assign col_inc = r_col_idx + 5'd1;
    assign rd_in_range = r_char_idx < DEPTH_LIM;
    assign wr_in_range = i_write_position < DEPTH_LIM;

    always_comb begin
        unique case (r_row_idx)
            2'd1:    row_addr = ROW2_ADDR[6:0];
            2'd2:    row_addr = r_row3_addr;
            2'd3:    row_addr = r_row4_addr;
            default: row_addr = 7'd0;
        endcase
    end

    // one sequencer step
    always_comb begin
        n_init_done  = r_init_done;
        n_data_phase = r_data_phase;
        n_strobe_all = r_strobe_all;
        n_sel        = r_sel;
        n_init_step  = r_init_step;
        n_wait       = r_wait;
        n_char_idx   = r_char_idx;
        n_col_idx    = r_col_idx;
        n_row_idx    = r_row_idx;
        pend         = r_low_pend;
        s0.src        = SRC_KEEP;
        s0.const_byte = CMD_SET_ADDR;
        s0.nib        = r_nibble_mode;
        s0.enable     = 1'b0;
        if (!(r_nibble_mode && r_low_pend)) begin
            if (r_init_done) begin
                if (r_data_phase) begin
                    n_sel      = 1'b1;
                    s0.src     = SRC_MEM;
                    n_char_idx = r_char_idx + 7'd1;
                    n_col_idx  = col_inc;
                    if (col_inc >= cols) begin
                        n_col_idx    = 5'd0;
                        n_row_idx    = r_row_idx + 2'd1;
                        n_data_phase = 1'b0;
                    end
                end else begin
                    n_sel  = 1'b0;
                    s0.src = SRC_CONST;
                    if (r_char_idx >= span) begin
                        // past the display span (also after a shrink): restart at the top row
                        n_char_idx    = 7'd0;
                        n_col_idx     = 5'd0;
                        n_row_idx     = 2'd0;
                        s0.const_byte = CMD_SET_ADDR;
                    end else begin
                        s0.const_byte = CMD_SET_ADDR | {1'b0, row_addr};
                    end
                    n_data_phase = 1'b1;
                end
            end else begin
                n_sel = 1'b0;
                if (r_wait == 7'd0) begin
                    if (r_init_step == 4'd0) begin
                        n_wait = WAIT_LONG;
                    end else if (r_init_step == 4'd1) begin
                        n_wait        = WAIT_SHORT;
                        s0.src        = SRC_CONST;
                        s0.const_byte = CMD_WAKE;
                        s0.enable     = 1'b1;
                    end else begin
                        s0.src        = SRC_CONST;
                        s0.const_byte = power_up_byte(r_init_step, r_nibble_mode,
                                                      rows >= 3'd2);
                        s0.enable     = 1'b1;
                    end
                    if (r_nibble_mode) begin
                        if (r_init_step < FIRST_FULL_NIB) pend = 1'b1;
                        else n_strobe_all = 1'b1;
                    end
                    if (r_init_step > (r_nibble_mode ? LAST_STEP_NIB : LAST_STEP_BYTE)) begin
                        n_strobe_all = 1'b1;
                        n_init_done  = 1'b1;
                        n_init_step  = 4'd0;
                        n_char_idx   = span;
                        n_col_idx    = 5'd0;
                        n_row_idx    = 2'd0;
                    end else begin
                        n_init_step = r_init_step + 4'd1;
                    end
                end else begin
                    n_wait = r_wait - 7'd1;
                end
            end
        end
        n_low_pend = pend;
        s0.shift   = 1'b0;
        if (r_nibble_mode) begin
            if (pend) begin
                n_low_pend = 1'b0;
            end else begin
                n_low_pend = 1'b1;
                s0.shift   = 1'b1;
            end
        end
        s0.sel    = n_sel;
        s0.enable = s0.enable | n_strobe_all;
    end

    // configuration and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= 3'd2;
            r_col_count   <= 5'd16;
            r_nibble_mode <= 1'b1;
            r_row3_addr   <= 7'd20;
            r_row4_addr   <= 7'd84;
            r_init_done   <= 1'b0;
            r_data_phase  <= 1'b0;
            r_low_pend    <= 1'b0;
            r_strobe_all  <= 1'b0;
            r_sel         <= 1'b0;
            r_init_step   <= 4'd0;
            r_wait        <= 7'd0;
            r_char_idx    <= 7'd0;
            r_col_idx     <= 5'd0;
            r_row_idx     <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[2:0];
                    CFG_COL_COUNT:   r_col_count   <= i_cfg_data[4:0];
                    CFG_NIBBLE_MODE: r_nibble_mode <= i_cfg_data[0];
                    CFG_ROW3_ADDR:   r_row3_addr   <= i_cfg_data;
                    CFG_ROW4_ADDR:   r_row4_addr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (tick_acc) begin
                r_init_done  <= n_init_done;
                r_data_phase <= n_data_phase;
                r_low_pend   <= n_low_pend;
                r_strobe_all <= n_strobe_all;
                r_sel        <= n_sel;
                r_init_step  <= n_init_step;
                r_wait       <= n_wait;
                r_char_idx   <= n_char_idx;
                r_col_idx    <= n_col_idx;
                r_row_idx    <= n_row_idx;
            end
        end
    end

    // Buffer port. Reads and writes come from distinct items at distinct edges, so a
    // read always sees every earlier write.
    always_ff @(posedge i_clk) begin
        if (wr_acc && wr_in_range) begin
            mem[i_write_position[AW-1:0]] <= i_write_char;
        end
        if (tick_acc) begin
            r_rd_data <= mem[r_char_idx[AW-1:0]];
            r_s1      <= s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (wr_acc && wr_in_range) begin
                r_mem_valid[i_write_position[AW-1:0]] <= 1'b1;
            end
            if (tick_acc) begin
                r_rd_ok <= rd_in_range && r_mem_valid[r_char_idx[AW-1:0]];
            end
        end
    end

    // output stage
    always_comb begin
        unique case (r_s1.src)
            SRC_MEM:   cb = r_rd_ok ? r_rd_data : 8'h00;
            SRC_CONST: cb = r_s1.const_byte;
            default:   cb = r_cur_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_cur_byte <= 8'h00;
        end else begin
            if (tick_acc) r_s1_valid <= 1'b1;
            else if (s1_adv) r_s1_valid <= 1'b0;
            if (s1_adv) begin
                r_o_valid  <= 1'b1;
                r_cur_byte <= r_s1.shift ? {cb[3:0], 4'h0} : cb;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_bus_data        <= r_s1.nib ? {cb[7:4], 4'h0} : cb;
            o_register_select <= r_s1.sel;
            o_enable_strobe   <= r_s1.enable;
        end
    end

endmodule

/* design/clrc_checker.sv */
// Port-level checks for the character LCD refresh controller, bound to the top level.
// No package dependencies; sees only the top-level handshake and result ports.
module clrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_bus_data,
    input logic       o_register_select,
    input logic       o_enable_strobe
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_bus_data) && $stable(o_register_select)
                               && $stable(o_enable_strobe))
        else $error("stalled result changed");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

bind character_lcd_refresh_controller clrc_checker u_clrc_checker (.*);

/* tb/tb_character_lcd_refresh_controller.sv */
// Testbench for the character LCD refresh controller: a directed table, then random phases
// across register settings, every bus step checked against an in-bench bus-step predictor.
// Depends on clrc_pkg and character_lcd_refresh_controller.
module tb_character_lcd_refresh_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import clrc_pkg::*;

    localparam int DEPTH           = 80;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PHASE_ITEMS     = 130;
    localparam int PHASES          = 10;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // indexes past the register list, written once to see that they change nothing
    localparam logic [2:0] CFG_SPARE_5 = 3'd5;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam logic [7:0] CMD_FOUR_BIT    = 8'h20;
    localparam logic [7:0] FSET_NIB_MULTI  = 8'h28;
    localparam logic [7:0] FSET_BYTE_MULTI = 8'h38;
    localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_DISP_ON     = 8'h0C;

    typedef struct packed {
        logic [7:0] bus_data;
        logic       register_select;
        logic       enable_strobe;
    } t_lcd_step;

    typedef struct packed {
        logic       op;
        logic [6:0] pos;
        logic [7:0] chr;
        logic       quiet;    // expected step typed in: all low
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [2:0] i_cfg_index;
    logic [6:0] i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    logic       i_op;
    logic [6:0] i_write_position;
    logic [7:0] i_write_char;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_bus_data;
    logic       o_register_select;
    logic       o_enable_strobe;

    character_lcd_refresh_controller #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_write_position (i_write_position),
        .i_write_char     (i_write_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_bus_data       (o_bus_data),
        .o_register_select(o_register_select),
        .o_enable_strobe  (o_enable_strobe)
    );

    // predictor copy of the registers
    logic [2:0] rows_cfg  = 3'd2;
    logic [4:0] cols_cfg  = 5'd16;
    logic       nib_cfg   = 1'b1;
    logic [6:0] row3_cfg  = 7'd20;
    logic [6:0] row4_cfg  = 7'd84;

    // predictor copy of the sequencer and the text buffer
    logic [7:0] text_mirror [DEPTH];
    logic       pwr_done     = 1'b0;
    logic       data_phase   = 1'b0;
    logic       low_half_due = 1'b0;
    logic       strobe_all   = 1'b0;
    logic       sel_level    = 1'b0;
    logic [3:0] pwr_step     = '0;
    logic [6:0] wait_left    = '0;
    logic [6:0] char_idx     = '0;
    logic [4:0] col_idx      = '0;
    logic [1:0] row_idx      = '0;
    logic [7:0] cur_byte     = '0;

    t_lcd_step bus_steps_due [$];
    int        fail_count   = 0;
    int        results_seen = 0;
    int        idle_cycles  = 0;
    int        burst_left   = 0;

    initial begin
        for (int k = 0; k < DEPTH; k++) text_mirror[k] = 8'h00;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned rows_now();
        if (rows_cfg == 3'd0) return 1;
        if (rows_cfg > 3'd4) return 4;
        return rows_cfg;
    endfunction

    function automatic int unsigned cols_now();
        return (cols_cfg == 5'd0) ? 1 : cols_cfg;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [3:0] s, input logic nib,
                                            input logic multi);
        logic [7:0] b;
        b = CMD_DISP_ON;
        if (s == 4'd2 || s == 4'd3) begin
            b = CMD_WAKE;
        end else if (nib) begin
            case (s)
                4'd4: b = CMD_FOUR_BIT;
                4'd5: b = multi ? FSET_NIB_MULTI : CMD_FOUR_BIT;
                4'd6: b = CMD_DISP_OFF;
                4'd7: b = CMD_ENTRY_MODE;
                default: b = CMD_DISP_ON;
            endcase
        end else begin
            case (s)
                4'd4: b = multi ? FSET_BYTE_MULTI : CMD_WAKE;
                4'd5: b = CMD_DISP_OFF;
                4'd6: b = CMD_ENTRY_MODE;
                default: b = CMD_DISP_ON;
            endcase
        end
        return b;
    endfunction

    // Advances the predictor by one item; a tick yields the bus step it drives.
    task automatic next_bus_step(input logic op, input logic [6:0] pos, input logic [7:0] chr,
                                 output logic produced, output t_lcd_step step);
        int unsigned rows, cols, span;
        logic [3:0]  s;
        logic        nib, en;
        logic [6:0]  addr;
        rows = rows_now();
        cols = cols_now();
        span = rows * cols;
        nib = nib_cfg;
        en = 1'b0;
        produced = 1'b0;
        step = '0;
        if (op == OP_WRITE) begin
            if (pos < DEPTH) text_mirror[pos] = chr;
        end else begin
            // second half of a nibble pair: the sequencer holds still
            if (!(nib && low_half_due)) begin
                if (pwr_done) begin
                    if (data_phase) begin
                        sel_level = 1'b1;
                        cur_byte = (char_idx < DEPTH) ? text_mirror[char_idx] : 8'h00;
                        char_idx = char_idx + 7'd1;
                        col_idx = col_idx + 5'd1;
                        if (col_idx >= cols) begin
                            col_idx = '0;
                            row_idx = row_idx + 2'd1;
                            data_phase = 1'b0;
                        end
                    end else begin
                        sel_level = 1'b0;
                        case (row_idx)
                            2'd1: addr = ROW2_ADDR[6:0];
                            2'd2: addr = row3_cfg;
                            2'd3: addr = row4_cfg;
                            default: addr = '0;
                        endcase
                        // past the display span (also after a shrink): back to row 0
                        if (char_idx >= span) begin
                            char_idx = '0;
                            col_idx = '0;
                            row_idx = '0;
                            cur_byte = CMD_SET_ADDR;
                        end else begin
                            cur_byte = CMD_SET_ADDR | {1'b0, addr};
                        end
                        data_phase = 1'b1;
                    end
                end else begin
                    sel_level = 1'b0;
                    if (wait_left == '0) begin
                        s = pwr_step;
                        if (s == 4'd0) begin
                            wait_left = WAIT_LONG;
                        end else if (s == 4'd1) begin
                            wait_left = WAIT_SHORT;
                            cur_byte = CMD_WAKE;
                            en = 1'b1;
                        end else begin
                            cur_byte = init_cmd(s, nib, rows >= 2);
                            en = 1'b1;
                        end
                        if (nib) begin
                            if (s < FIRST_FULL_NIB) low_half_due = 1'b1;
                            else strobe_all = 1'b1;
                        end
                        if (s > (nib ? LAST_STEP_NIB : LAST_STEP_BYTE)) begin
                            strobe_all = 1'b1;
                            pwr_done = 1'b1;
                            pwr_step = '0;
                            char_idx = span[6:0];
                            col_idx = '0;
                            row_idx = '0;
                        end else begin
                            pwr_step = s + 4'd1;
                        end
                    end else begin
                        wait_left = wait_left - 7'd1;
                    end
                end
            end
            step.bus_data = nib ? (cur_byte & 8'hF0) : cur_byte;
            step.register_select = sel_level;
            if (nib) begin
                if (low_half_due) begin
                    low_half_due = 1'b0;
                end else begin
                    cur_byte = cur_byte << 4;
                    low_half_due = 1'b1;
                end
            end
            step.enable_strobe = en | strobe_all;
            produced = 1'b1;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_item(input logic op, input logic [6:0] pos, input logic [7:0] chr,
                              input logic quiet);
        logic      produced;
        t_lcd_step step;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid = 1'b1;
        i_op = op;
        i_write_position = pos;
        i_write_char = chr;
        do @(posedge i_clk); while (o_stall);
        next_bus_step(op, pos, chr, produced, step);
        if (produced) bus_steps_due.push_back(quiet ? t_lcd_step'('0) : step);
        @(negedge i_clk);
    endtask

    task automatic offer_random();
        logic        op;
        logic [6:0]  pos;
        int unsigned span;
        span = rows_now() * cols_now();
        op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_TICK;
        // most writes land inside the shown span so that they come back on the bus
        if (op == OP_WRITE && $urandom_range(0, 3) != 0) pos = 7'($urandom_range(0, span - 1));
        else pos = 7'($urandom_range(0, 127));
        offer_item(op, pos, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            CFG_ROW_COUNT:   rows_cfg = val[2:0];
            CFG_COL_COUNT:   cols_cfg = val[4:0];
            CFG_NIBBLE_MODE: nib_cfg = val[0];
            CFG_ROW3_ADDR:   row3_cfg = val;
            CFG_ROW4_ADDR:   row4_cfg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic apply_settings(input logic [2:0] rows, input logic [4:0] cols,
                                  input logic nib, input logic [6:0] a3, input logic [6:0] a4);
        write_reg(CFG_ROW_COUNT, {4'd0, rows});
        write_reg(CFG_COL_COUNT, {2'd0, cols});
        write_reg(CFG_NIBBLE_MODE, {6'd0, nib});
        write_reg(CFG_ROW3_ADDR, a3);
        write_reg(CFG_ROW4_ADDR, a4);
    endtask

    // all results in, then a few cycles for a write item still in the pipe
    task automatic settle();
        i_valid = 1'b0;
        while (bus_steps_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_dir_row script_row(input logic op, input logic [6:0] pos,
                                            input logic [7:0] chr, input logic quiet);
        t_dir_row r;
        r.op = op;
        r.pos = pos;
        r.chr = chr;
        r.quiet = quiet;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_lcd_step want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (bus_steps_due.size() == 0) begin
                $error("bus step with none expected: bus_data %02h rs %b en %b",
                       o_bus_data, o_register_select, o_enable_strobe);
                fail_count++;
            end else begin
                want = bus_steps_due.pop_front();
                if (o_bus_data !== want.bus_data) begin
                    $error("bus_data: expected %02h, got %02h", want.bus_data, o_bus_data);
                    fail_count++;
                end
                if (o_register_select !== want.register_select) begin
                    $error("register_select: expected %b, got %b",
                           want.register_select, o_register_select);
                    fail_count++;
                end
                if (o_enable_strobe !== want.enable_strobe) begin
                    $error("enable_strobe: expected %b, got %b",
                           want.enable_strobe, o_enable_strobe);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("character_lcd_refresh_controller: mismatch");
        $finish;
    end

    // receiver: stall pattern that changes now and then, plus one long hold-off
    // taken while the sender is offering, so the block fills and stalls its input
    initial begin : stall_pattern
        t_stall_mode mode;
        int          left;
        logic        held_off;
        i_stall = 1'b0;
        mode = STALL_NONE;
        left = 0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= 400 && bus_steps_due.size() > 0 && i_valid) begin
                held_off = 1'b1;
                i_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(32, 200);
            end
            left--;
            case (mode)
                STALL_NONE:  i_stall = 1'b0;
                STALL_LIGHT: i_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall = ($urandom_range(0, 3) != 0);
                default:     i_stall = ~i_stall;
            endcase
        end
    end

    initial begin : stimulus
        t_dir_row script [$];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_op = OP_TICK;
        i_write_position = '0;
        i_write_char = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // early ticks sit inside the power-up wait, so every line on the bus is low
        script.push_back(script_row(OP_TICK,  7'd0,   8'h00, 1'b1));
        script.push_back(script_row(OP_TICK,  7'd127, 8'hFF, 1'b1));
        script.push_back(script_row(OP_WRITE, 7'd0,   8'hFF, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd79,  8'h81, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd80,  8'hAA, 1'b0));   // past depth: dropped
        script.push_back(script_row(OP_WRITE, 7'd127, 8'h55, 1'b0));
        script.push_back(script_row(OP_TICK,  7'd85,  8'hAA, 1'b1));
        script.push_back(script_row(OP_WRITE, 7'd1,   8'h7F, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd19,  8'h20, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd20,  8'h41, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd40,  8'h80, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd60,  8'h01, 1'b0));
        script.push_back(script_row(OP_TICK,  7'd42,  8'h55, 1'b1));
        script.push_back(script_row(OP_WRITE, 7'd2,   8'hFE, 1'b0));
        script.push_back(script_row(OP_WRITE, 7'd64,  8'h00, 1'b0));
        script.push_back(script_row(OP_TICK,  7'd0,   8'h00, 1'b1));
        for (int k = 0; k < 6; k++)
            script.push_back(script_row(OP_TICK, 7'($urandom_range(0, 127)),
                                        8'($urandom_range(0, 255)), 1'b0));
        foreach (script[k]) offer_item(script[k].op, script[k].pos, script[k].chr, script[k].quiet);

        // one row during power-up, then switch to byte mode one step past its list
        settle();
        write_reg(CFG_ROW_COUNT, 7'd0);
        while (!pwr_done && pwr_step <= LAST_STEP_NIB) offer_random();

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: apply_settings(3'd4, 5'd20, 1'b0, 7'd0, 7'd127);
                1: apply_settings(3'd1, 5'd1, 1'b1, 7'd127, 7'd0);
                2: apply_settings(3'd3, 5'd16, 1'b0, 7'($urandom_range(0, 127)), 7'd84);
                3: apply_settings(3'd7, 5'd31, 1'b1, 7'd127, 7'd127);   // reads past depth
                4: apply_settings(3'd5, 5'd0, 1'b0, 7'd0, 7'd0);
                5: apply_settings(3'd0, 5'd20, 1'b1, 7'd20, 7'd84);
                6: apply_settings(3'd2, 5'd20, 1'b0, 7'd1, 7'd126);
                default: apply_settings(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                                        1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                                        7'($urandom_range(0, 127)));
            endcase
            if (ph == 3) begin
                write_reg(CFG_SPARE_5, 7'($urandom_range(0, 127)));
                write_reg(CFG_SPARE_7, 7'($urandom_range(0, 127)));
            end
            repeat (PHASE_ITEMS) offer_random();
        end

        settle();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0)
            $display("character_lcd_refresh_controller: match");
        else
            $display("character_lcd_refresh_controller: mismatch");
        $finish;
    end

endmodule
